>>> src/tsc_pkg.sv
package tsc_pkg;

    localparam int unsigned CNT_W     = 64;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned FREQ_W    = 33;
    localparam int unsigned SEC_W     = 35;
    localparam int unsigned NSEC_W    = 30;
    localparam int unsigned MPLIER_W  = 30;
    localparam int unsigned ALU_W     = 65;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned MUL_STEPS = 30;
    localparam int unsigned DIV_STEPS = 64;

    localparam logic [MPLIER_W-1:0] TICK_HZ    = 30'd1193182;
    localparam logic [MPLIER_W-1:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [CNT_W-1:0]    FREQ_MIN     = 64'd100000000;
    localparam logic [CNT_W-1:0]    FREQ_MAX     = 64'd5000000000;
    localparam logic [FREQ_W-1:0]   FREQ_DEFAULT = 33'd2400000000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNCAL     = 2'd1;
    localparam logic [1:0] ST_DEFAULTED = 2'd2;

    localparam logic ACT_CALIBRATE = 1'b0;
    localparam logic ACT_CONVERT   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CNT_W-1:0]  cycle_count;
        logic [TICK_W-1:0] ref_tick_delta;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [SEC_W-1:0]  seconds;
        logic [NSEC_W-1:0] nanoseconds;
    } t_res;

    typedef struct packed {
        logic idle;
        logic mul_step;
        logic div_setup;
        logic div_step;
        logic finish;
        logic pass;
    } t_seq_ctl;

endpackage

>>> src/tsc_calibrate_and_time_convert_unit.sv
// Cycle-counter calibration and counter-to-time conversion.
// Command channel: i_cmd is taken at a rising edge with i_start high and
// o_busy low. action 0 calibrates the stored frequency from a cycle delta
// and a reference tick delta; action 1 converts a counter value to whole
// seconds and nanoseconds.
// Result channel: o_valid is high for exactly one cycle with o_result; the
// receiver cannot hold it off.
// A calibrate with a frequency already stored, or a convert with none
// stored, answers in the cycle after acceptance. A calibration runs 30
// shift-add multiply steps, one setup, 64 division steps and one range
// check; a conversion adds a second setup and 64-step division that
// splits seconds from nanoseconds. All steps share one 65-bit adder/
// subtractor; o_busy stays high for the whole transaction, so the unit
// takes no new command until the last one has finished.
// Reset clears the stored frequency (not calibrated) and the sequencer.
module tsc_calibrate_and_time_convert_unit
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_valid,
    output t_res o_result
);

    t_seq_ctl w_ctl;

    logic [CNT_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_mcand;
    logic [MPLIER_W-1:0] r_mplier;
    logic [CNT_W-1:0]    r_quo;
    logic [FREQ_W-1:0]   r_rem;
    logic [FREQ_W-1:0]   r_div;
    logic [TICK_W-1:0]   r_ticks;
    logic                r_action;
    logic [FREQ_W-1:0]   r_freq;
    logic                r_valid;
    t_res                r_res;

    logic             w_accept;
    logic             w_early;
    logic [1:0]       w_early_status;
    logic [FREQ_W:0]  w_shifted;
    logic [ALU_W-1:0] w_a;
    logic [ALU_W-1:0] w_b;
    logic [ALU_W-1:0] w_y;
    logic             w_out_of_range;

    assign w_accept = i_start && w_ctl.idle;
    assign w_early  = ((i_cmd.action == ACT_CALIBRATE) && (r_freq != '0)) ||
                      ((i_cmd.action == ACT_CONVERT) && (r_freq == '0));
    assign w_early_status = (i_cmd.action == ACT_CONVERT) ? ST_UNCAL : ST_OK;

    assign w_shifted = {r_rem, r_quo[CNT_W-1]};

    always_comb begin
        if (w_ctl.div_step) begin
            w_a = ALU_W'(w_shifted);
            w_b = ALU_W'(r_div);
        end else begin
            w_a = ALU_W'(r_acc);
            w_b = ALU_W'(r_mcand);
        end
    end

    tsc_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_ctl.div_step),
        .o_y   (w_y)
    );

    tsc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_accept && !w_early),
        .i_action (r_action),
        .o_ctl    (w_ctl)
    );

    assign w_out_of_range = (r_quo < FREQ_MIN) || (r_quo > FREQ_MAX);

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_early) begin
            r_acc    <= '0;
            r_mcand  <= i_cmd.cycle_count;
            r_mplier <= (i_cmd.action == ACT_CONVERT) ? NS_PER_SEC : TICK_HZ;
            r_ticks  <= i_cmd.ref_tick_delta;
            r_action <= i_cmd.action;
        end
        if (w_ctl.mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= w_y[CNT_W-1:0];
            end
            r_mcand  <= {r_mcand[CNT_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MPLIER_W-1:1]};
        end
        if (w_ctl.div_setup) begin
            r_rem <= '0;
            if (!w_ctl.pass) begin
                r_quo <= r_acc;
                if (r_action == ACT_CONVERT) begin
                    r_div <= r_freq;
                end else if (r_ticks == '0) begin
                    r_div <= FREQ_W'(1);
                end else begin
                    r_div <= FREQ_W'(r_ticks);
                end
            end else begin
                r_div <= FREQ_W'(NS_PER_SEC);
            end
        end
        if (w_ctl.div_step) begin
            if (!w_y[ALU_W-1]) begin
                r_rem <= w_y[FREQ_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[FREQ_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], 1'b0};
            end
        end
        if (w_accept && w_early) begin
            r_res.status      <= w_early_status;
            r_res.seconds     <= '0;
            r_res.nanoseconds <= '0;
        end else if (w_ctl.finish) begin
            if (r_action == ACT_CONVERT) begin
                r_res.status      <= ST_OK;
                r_res.seconds     <= r_quo[SEC_W-1:0];
                r_res.nanoseconds <= r_rem[NSEC_W-1:0];
            end else begin
                r_res.status      <= w_out_of_range ? ST_DEFAULTED : ST_OK;
                r_res.seconds     <= '0;
                r_res.nanoseconds <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_accept && w_early) || w_ctl.finish;
            if (w_ctl.finish && r_action == ACT_CALIBRATE) begin
                r_freq <= w_out_of_range ? FREQ_DEFAULT : r_quo[FREQ_W-1:0];
            end
        end
    end

    assign o_busy   = !w_ctl.idle;
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_freq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_freq != '0) |=> (r_freq != '0))
        else $error("stored frequency lost");
    a_freq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_freq == '0) || ((CNT_W'(r_freq) >= FREQ_MIN) && (CNT_W'(r_freq) <= FREQ_MAX)))
        else $error("stored frequency out of range");
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_UNCAL) |->
        (o_result.seconds == '0 && o_result.nanoseconds == '0))
        else $error("uncalibrated result carries a time");
    a_ns_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.nanoseconds < NS_PER_SEC))
        else $error("nanosecond field not below one second");
`endif

endmodule

>>> src/tsc_alu.sv
module tsc_alu
    import tsc_pkg::*;
(
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ALU_W-1:0] o_y
);

    logic [ALU_W-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;
    assign o_y = i_a + w_b + {{(ALU_W-1){1'b0}}, i_sub};

endmodule

>>> src/tsc_seq.sv
module tsc_seq
    import tsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_go,
    input  logic     i_action,
    output t_seq_ctl o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DSET = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_pass, n_pass;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                    n_pass  = 1'b0;
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_DSET;
                end
            end
            S_DSET: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    if (i_action == ACT_CONVERT && !r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_DSET;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    assign o_ctl.idle      = (r_state == S_IDLE);
    assign o_ctl.mul_step  = (r_state == S_MUL);
    assign o_ctl.div_setup = (r_state == S_DSET);
    assign o_ctl.div_step  = (r_state == S_DIV);
    assign o_ctl.finish    = (r_state == S_FIN);
    assign o_ctl.pass      = r_pass;

`ifndef SYNTHESIS
    a_go_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_go) |=> (r_state == S_MUL))
        else $error("sequencer did not start multiply");
    a_second_pass_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pass && r_state != S_IDLE) |-> (i_action == ACT_CONVERT))
        else $error("second division on a calibrate transaction");
`endif

endmodule

>>> tb/sv/tsc_calibrate_and_time_convert_unit_tb.sv
`timescale 1ns / 100ps

module tsc_calibrate_and_time_convert_unit_tb;
    import tsc_pkg::*;

    localparam int                N_RANDOM     = 1930;
    localparam int                N_CALM_TAIL  = 300;
    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 200;
    localparam longint unsigned   PIT_HZ       = 64'd1193182;
    localparam longint unsigned   NSEC_PER_S   = 64'd1000000000;
    localparam longint unsigned   F_LOW        = 64'd100000000;
    localparam longint unsigned   F_HIGH       = 64'd5000000000;
    localparam logic [FREQ_W-1:0] F_FALLBACK   = 33'd2400000000;

    typedef struct {
        t_cmd cmd;
        bit   pinned;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_cmd i_cmd;
    logic o_busy;
    logic o_valid;
    t_res o_result;

    logic [FREQ_W-1:0] cal_freq_hz;
    t_res              pending_outcomes[$];
    bit                pin_en;
    t_res              pin_res;
    bit                idle_on;
    int                n_fail;
    int                quiet_cycles;

    tsc_calibrate_and_time_convert_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_cmd mk_cmd(logic act, logic [CNT_W-1:0] cyc, logic [TICK_W-1:0] tk);
        t_cmd c;
        c.action         = act;
        c.cycle_count    = cyc;
        c.ref_tick_delta = tk;
        return c;
    endfunction

    function automatic t_res mk_res(logic [1:0] st);
        t_res r;
        r.status      = st;
        r.seconds     = '0;
        r.nanoseconds = '0;
        return r;
    endfunction

    // Works out the answer to one command and updates the held frequency.
    function automatic t_res tsc_outcome(t_cmd c);
        t_res             r;
        logic [63:0]      prod;
        logic [63:0]      freq;
        logic [63:0]      ticks;
        logic [63:0]      ns_total;
        logic [63:0]      secs;
        logic [63:0]      ns_rem;
        r = mk_res(ST_OK);
        if (c.action == ACT_CALIBRATE) begin
            if (cal_freq_hz != '0)
                return r;
            ticks = (c.ref_tick_delta == '0) ? 64'd1 : {32'd0, c.ref_tick_delta};
            prod  = c.cycle_count * PIT_HZ;
            freq  = prod / ticks;
            if (freq < F_LOW || freq > F_HIGH) begin
                cal_freq_hz = F_FALLBACK;
                r.status    = ST_DEFAULTED;
            end else begin
                cal_freq_hz = freq[FREQ_W-1:0];
            end
            return r;
        end
        if (cal_freq_hz == '0) begin
            r.status = ST_UNCAL;
            return r;
        end
        prod          = c.cycle_count * NSEC_PER_S;
        ns_total      = prod / {31'd0, cal_freq_hz};
        secs          = ns_total / NSEC_PER_S;
        ns_rem        = ns_total - secs * NSEC_PER_S;
        r.seconds     = secs[SEC_W-1:0];
        r.nanoseconds = ns_rem[NSEC_W-1:0];
        return r;
    endfunction

    function automatic t_cmd random_cmd();
        logic [CNT_W-1:0] cyc;
        logic             act;
        act = ($urandom_range(99, 0) < 85) ? ACT_CONVERT : ACT_CALIBRATE;
        case ($urandom_range(4, 0))
            0: cyc = {$urandom, $urandom};
            1: cyc = 64'($urandom_range(100000, 0));
            2: cyc = 64'd18446744073 + 64'($urandom_range(20, 0)) - 64'd10;
            3: cyc = {$urandom, $urandom} >> $urandom_range(63, 0);
            default: cyc = {$urandom, $urandom} | (64'd1 << 63);
        endcase
        return mk_cmd(act, cyc, $urandom);
    endfunction

    task automatic issue(t_cmd c);
        if (idle_on && $urandom_range(2, 0) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(19, 1)) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // Result check comes first so a same-edge acceptance cannot reorder the queue.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result with no transaction outstanding: %h", o_result);
                    n_fail++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        n_fail++;
                    end
                    if (o_result.seconds !== want.seconds) begin
                        $error("seconds: expected %0d, got %0d", want.seconds,
                               o_result.seconds);
                        n_fail++;
                    end
                    if (o_result.nanoseconds !== want.nanoseconds) begin
                        $error("nanoseconds: expected %0d, got %0d", want.nanoseconds,
                               o_result.nanoseconds);
                        n_fail++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                want = tsc_outcome(i_cmd);
                pending_outcomes.push_back(pin_en ? pin_res : want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row       rows[$];
        t_cmd       cal;
        logic [63:0] ones;
        ones         = '1;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = '0;
        pin_en       = 1'b0;
        pin_res      = '0;
        idle_on      = 1'b1;
        n_fail       = 0;
        quiet_cycles = 0;
        cal_freq_hz  = '0;

        // the one real calibration of the run: pick its flavour per seed
        case ($urandom_range(3, 0))
            0: cal = mk_cmd(ACT_CALIBRATE, 64'd2011, 32'd0);
            1: cal = mk_cmd(ACT_CALIBRATE, ones, 32'hFFFF_FFFF);
            2: cal = mk_cmd(ACT_CALIBRATE, 64'd1, 32'd1);
            default: cal = mk_cmd(ACT_CALIBRATE, 64'd1 << 40, 32'd0);
        endcase

        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd0, 32'd0), 1'b1, mk_res(ST_UNCAL)});
        rows.push_back('{mk_cmd(ACT_CONVERT, ones, 32'hFFFF_FFFF), 1'b1, mk_res(ST_UNCAL)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA), 1'b1,
                         mk_res(ST_UNCAL)});
        rows.push_back('{cal, 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CALIBRATE, ones, 32'd0), 1'b1, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CALIBRATE, 64'd0, 32'd0), 1'b1, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CALIBRATE, 64'd1, 32'd1), 1'b1, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd0, 32'hFFFF_FFFF), 1'b1, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd1, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, ones, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd1 << 63, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd18446744073, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd18446744074, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd2400000000, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd4294967296, 32'd0), 1'b0, mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555), 1'b0,
                         mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA), 1'b0,
                         mk_res(ST_OK)});
        rows.push_back('{mk_cmd(ACT_CONVERT, 64'd999999999, 32'd0), 1'b0, mk_res(ST_OK)});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            pin_en  = rows[k].pinned;
            pin_res = rows[k].res;
            issue(rows[k].cmd);
        end
        pin_en = 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = (n < N_RANDOM - N_CALM_TAIL) && ((n / 150) % 3 != 2);
            issue(random_cmd());
        end
        i_start <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d transactions never answered", pending_outcomes.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
